/* rtl/core/mpce_pkg.sv */
package mpce_pkg;

  localparam int DATA_WIDTH_DEF     = 8;
  localparam int MAX_IMAGE_COLS_DEF = 256;
  localparam int MAX_IMAGE_ROWS_DEF = 256;

  localparam int POOL_REG_W = 5;
  localparam int IMG_REG_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int WIN_CNT_W  = 4;
  localparam int OUTQ_DEPTH = 3;

  localparam logic [POOL_REG_W-1:0] POOL_MAX = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd3;

  localparam logic [POOL_REG_W-1:0] POOL_ROWS_RST  = 5'd2;
  localparam logic [POOL_REG_W-1:0] POOL_COLS_RST  = 5'd2;
  localparam logic [IMG_REG_W-1:0]  IMAGE_ROWS_RST = 9'd4;
  localparam logic [IMG_REG_W-1:0]  IMAGE_COLS_RST = 9'd4;

  // control flags for one sample, from the counter block to the update stage
  typedef struct packed {
    logic first;  // opens a window: running max starts at the floor
    logic emit;   // closes a window
    logic eoi;    // last sample of the image
  } win_info_t;

  function automatic logic [POOL_REG_W-1:0] clamp_pool(input logic [POOL_REG_W-1:0] v);
    logic [POOL_REG_W-1:0] r;
    if (v == '0) begin
      r = 5'd1;
    end else if (v > POOL_MAX) begin
      r = POOL_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/core/mpce_ctrl.sv */
module mpce_ctrl #(
  parameter int MAX_IMAGE_COLS = mpce_pkg::MAX_IMAGE_COLS_DEF,
  parameter int MAX_IMAGE_ROWS = mpce_pkg::MAX_IMAGE_ROWS_DEF,
  localparam int CCW = $clog2(MAX_IMAGE_COLS),
  localparam int RCW = $clog2(MAX_IMAGE_ROWS)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [mpce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpce_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             advance,
  output mpce_pkg::win_info_t              info,
  output logic [CCW-1:0]                   idx
);

  localparam int CXW = CCW + 1;
  localparam int RXW = RCW + 1;

  logic [mpce_pkg::POOL_REG_W-1:0] pool_rows_r, pool_cols_r;
  logic [mpce_pkg::IMG_REG_W-1:0]  image_rows_r, image_cols_r;

  logic [RCW-1:0] rpos_r, rpos_nxt;
  logic [CCW-1:0] cpos_r, cpos_nxt;
  logic [mpce_pkg::WIN_CNT_W-1:0] riw_r, riw_nxt, ciw_r, ciw_nxt;
  logic [CCW-1:0] wci_r, wci_nxt;

  logic [mpce_pkg::POOL_REG_W-1:0] pr, pc;
  logic [RXW-1:0] ir;
  logic [CXW-1:0] ic;
  logic last_wcol, last_wrow, last_col, last_row;

  // effective sizes: zero reads as one, oversize saturates
  always_comb begin
    pr = mpce_pkg::clamp_pool(pool_rows_r);
    pc = mpce_pkg::clamp_pool(pool_cols_r);
    if (image_rows_r == '0) begin
      ir = RXW'(1);
    end else if (32'(image_rows_r) > 32'(MAX_IMAGE_ROWS)) begin
      ir = RXW'(MAX_IMAGE_ROWS);
    end else begin
      ir = RXW'(image_rows_r);
    end
    if (image_cols_r == '0) begin
      ic = CXW'(1);
    end else if (32'(image_cols_r) > 32'(MAX_IMAGE_COLS)) begin
      ic = CXW'(MAX_IMAGE_COLS);
    end else begin
      ic = CXW'(image_cols_r);
    end
  end

  assign last_wcol = ({1'b0, ciw_r} + 5'd1) >= pc;
  assign last_wrow = ({1'b0, riw_r} + 5'd1) >= pr;
  assign last_col  = ({1'b0, cpos_r} + CXW'(1)) >= ic;
  assign last_row  = ({1'b0, rpos_r} + RXW'(1)) >= ir;

  assign info.first = (riw_r == '0) && (ciw_r == '0);
  assign info.emit  = (last_wcol || last_col) && (last_wrow || last_row);
  assign info.eoi   = last_col && last_row;
  assign idx        = wci_r;

  always_comb begin
    rpos_nxt = rpos_r;
    cpos_nxt = cpos_r;
    riw_nxt  = riw_r;
    ciw_nxt  = ciw_r;
    wci_nxt  = wci_r;
    if (last_col) begin
      cpos_nxt = '0;
      ciw_nxt  = '0;
      wci_nxt  = '0;
      if (last_row) begin
        rpos_nxt = '0;
        riw_nxt  = '0;
      end else begin
        rpos_nxt = rpos_r + RCW'(1);
        riw_nxt  = last_wrow ? '0 : riw_r + 4'd1;
      end
    end else begin
      cpos_nxt = cpos_r + CCW'(1);
      if (last_wcol) begin
        ciw_nxt = '0;
        wci_nxt = wci_r + CCW'(1);
      end else begin
        ciw_nxt = ciw_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_rows_r  <= mpce_pkg::POOL_ROWS_RST;
      pool_cols_r  <= mpce_pkg::POOL_COLS_RST;
      image_rows_r <= mpce_pkg::IMAGE_ROWS_RST;
      image_cols_r <= mpce_pkg::IMAGE_COLS_RST;
      rpos_r       <= '0;
      cpos_r       <= '0;
      riw_r        <= '0;
      ciw_r        <= '0;
      wci_r        <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mpce_pkg::CFG_POOL_ROWS:  pool_rows_r  <= cfg_data[mpce_pkg::POOL_REG_W-1:0];
          mpce_pkg::CFG_POOL_COLS:  pool_cols_r  <= cfg_data[mpce_pkg::POOL_REG_W-1:0];
          mpce_pkg::CFG_IMAGE_ROWS: image_rows_r <= cfg_data;
          mpce_pkg::CFG_IMAGE_COLS: image_cols_r <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        rpos_r <= rpos_nxt;
        cpos_r <= cpos_nxt;
        riw_r  <= riw_nxt;
        ciw_r  <= ciw_nxt;
        wci_r  <= wci_nxt;
      end
    end
  end

endmodule

/* rtl/core/mpce_colmem.sv */
module mpce_colmem #(
  parameter int DW    = mpce_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = mpce_pkg::MAX_IMAGE_COLS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/mpce_outq.sv */
module mpce_outq #(
  parameter int DW = mpce_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic signed [DW-1:0] push_value,
  input  logic                 push_eoi,
  input  logic                 pending,
  output logic                 can_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] out_pooled_value,
  output logic                 out_end_of_image
);

  localparam logic [1:0] LAST_SLOT = 2'(mpce_pkg::OUTQ_DEPTH - 1);

  logic [DW:0] slot_r [mpce_pkg::OUTQ_DEPTH];
  logic [1:0]  wr_ptr_r, rd_ptr_r, cnt_r;
  logic        pop;

  assign out_valid        = (cnt_r != '0);
  assign pop              = out_valid && out_ready;
  assign out_pooled_value = slot_r[rd_ptr_r][DW-1:0];
  assign out_end_of_image = slot_r[rd_ptr_r][DW];
  // room for the item in the update stage plus one more
  assign can_take = (3'(cnt_r) + 3'(pending)) < 3'(mpce_pkg::OUTQ_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= {push_eoi, push_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 2'd1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(mpce_pkg::OUTQ_DEPTH)) |-> !(push && !pop))
    else $error("result queue overflow");
`endif

endmodule

/* rtl/core/max_pool_2d_ceil_edges.sv */
// Streaming 2D max pooling, non-overlapping windows, ceil mode at the edges.
// in_*:  one signed sample per transfer, row-major, images back to back.
// out_*: one pooled value per completed window; out_end_of_image marks the
//        last window of each image.
// cfg_*: register writes (pool_rows, pool_cols, image_rows, image_cols),
//        taken every cycle; write only while the pipeline is empty.
// Throughput: one sample per cycle while the result queue has room. A sample
// reads its column's running max from the column store in the accept cycle;
// the next cycle does compare and write-back, with a bypass when back-to-back
// samples hit the same column. The result of the sample that closes a window
// is pushed into the queue from the update stage, and out_valid is high from
// then on.
// A 3-entry result queue decouples the sides; when the receiver stalls the
// queue fills and in_ready drops once no room is left for the sample in flight.
// Reset: counters return to the start of an image and the registers to 2x2
// windows on a 4x4 image. Store contents are left as is; every window
// overwrites its entry on its first sample, so no clearing pass is needed.
module max_pool_2d_ceil_edges #(
  parameter int DATA_WIDTH     = mpce_pkg::DATA_WIDTH_DEF,
  parameter int MAX_IMAGE_COLS = mpce_pkg::MAX_IMAGE_COLS_DEF,
  parameter int MAX_IMAGE_ROWS = mpce_pkg::MAX_IMAGE_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [DATA_WIDTH-1:0]    in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [DATA_WIDTH-1:0]    out_pooled_value,
  output logic                            out_end_of_image,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpce_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CCW = $clog2(MAX_IMAGE_COLS);
  // minus the largest positive sample value
  localparam logic signed [DATA_WIDTH-1:0] FLOOR = {1'b1, {(DATA_WIDTH-2){1'b0}}, 1'b1};

  mpce_pkg::win_info_t info;
  logic [CCW-1:0]      idx;
  logic                accept;

  logic                         s1_v_r;
  logic signed [DATA_WIDTH-1:0] s1_sample_r;
  mpce_pkg::win_info_t          s1_info_r;
  logic [CCW-1:0]               s1_idx_r;
  logic                         s1_fwd_r;
  logic signed [DATA_WIDTH-1:0] last_wdata_r;

  logic signed [DATA_WIDTH-1:0] rdata, base, cur;
  logic                         can_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_take;
  assign accept    = in_valid && in_ready;

  mpce_ctrl #(
    .MAX_IMAGE_COLS (MAX_IMAGE_COLS),
    .MAX_IMAGE_ROWS (MAX_IMAGE_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .info      (info),
    .idx       (idx)
  );

  mpce_colmem #(
    .DW    (DATA_WIDTH),
    .DEPTH (MAX_IMAGE_COLS)
  ) u_colmem (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_idx_r),
    .wdata (cur),
    .re    (accept),
    .raddr (idx),
    .rdata (rdata)
  );

  // the store still holds the old value if the previous sample writes the
  // same entry in the cycle this one reads it
  always_comb begin
    if (s1_info_r.first) begin
      base = FLOOR;
    end else if (s1_fwd_r) begin
      base = last_wdata_r;
    end else begin
      base = rdata;
    end
    cur = (s1_sample_r > base) ? s1_sample_r : base;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_sample;
      s1_info_r   <= info;
      s1_idx_r    <= idx;
      s1_fwd_r    <= s1_v_r && (s1_idx_r == idx);
    end
    if (s1_v_r) begin
      last_wdata_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  mpce_outq #(
    .DW (DATA_WIDTH)
  ) u_outq (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (s1_v_r && s1_info_r.emit),
    .push_value       (cur),
    .push_eoi         (s1_info_r.eoi),
    .pending          (s1_v_r),
    .can_take         (can_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pooled_value (out_pooled_value),
    .out_end_of_image (out_end_of_image)
  );

`ifndef SYNTHESIS
  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_fwd_r) |-> ($past(s1_v_r) && ($past(s1_idx_r) == s1_idx_r)))
    else $error("bypass taken without a matching write");
`endif

`ifndef SYNTHESIS
  a_eoi_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_info_r.eoi) |-> s1_info_r.emit)
    else $error("end of image without a result");
`endif

`ifndef SYNTHESIS
  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (cur != {1'b1, {(DATA_WIDTH-1){1'b0}}}))
    else $error("pooled value below floor");
`endif

endmodule

/* dv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW            = mpce_pkg::DATA_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 200;
  localparam int HOLD_CYCLES   = 100;

  typedef logic signed [DW-1:0]                 pixel_t;
  typedef logic [mpce_pkg::CFG_DATA_W-1:0]      cfg_word_t;
  typedef logic [mpce_pkg::CFG_IDX_W-1:0]       cfg_idx_t;

  localparam pixel_t PIX_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam pixel_t PIX_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam pixel_t FLOOR   = -PIX_MAX;

  typedef struct {
    pixel_t value;
    logic   eoi;
  } pooled_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  pixel_t    in_sample = '0;
  logic      out_ready = 1'b0;
  logic      cfg_valid = 1'b0;
  cfg_idx_t  cfg_index = mpce_pkg::CFG_POOL_ROWS;
  cfg_word_t cfg_data  = '0;
  logic      in_ready;
  logic      out_valid;
  pixel_t    out_pooled_value;
  logic      out_end_of_image;
  logic      cfg_ready;

  max_pool_2d_ceil_edges dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pooled_value (out_pooled_value),
    .out_end_of_image (out_end_of_image),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pooling predictor state
  logic [mpce_pkg::POOL_REG_W-1:0] pool_rows_r  = mpce_pkg::POOL_ROWS_RST;
  logic [mpce_pkg::POOL_REG_W-1:0] pool_cols_r  = mpce_pkg::POOL_COLS_RST;
  logic [mpce_pkg::IMG_REG_W-1:0]  image_rows_r = mpce_pkg::IMAGE_ROWS_RST;
  logic [mpce_pkg::IMG_REG_W-1:0]  image_cols_r = mpce_pkg::IMAGE_COLS_RST;
  pixel_t                          col_max [mpce_pkg::MAX_IMAGE_COLS_DEF];
  int unsigned row_pos = 0, col_pos = 0, row_in_win = 0, col_in_win = 0, win_col = 0;

  pooled_t pending_pools [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;

  int unsigned mismatches       = 0;
  int unsigned samples_sent     = 0;
  int unsigned results_checked  = 0;
  int unsigned reg_writes       = 0;
  int unsigned stall_cycles     = 0;
  int unsigned mid_image_writes = 0;

  function automatic int unsigned dim_used(int unsigned v, int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic bit at_image_start();
    return row_pos == 0 && col_pos == 0 && row_in_win == 0 && col_in_win == 0;
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, cfg_word_t data);
    case (idx)
      mpce_pkg::CFG_POOL_ROWS:  pool_rows_r  = data[mpce_pkg::POOL_REG_W-1:0];
      mpce_pkg::CFG_POOL_COLS:  pool_cols_r  = data[mpce_pkg::POOL_REG_W-1:0];
      mpce_pkg::CFG_IMAGE_ROWS: image_rows_r = data[mpce_pkg::IMG_REG_W-1:0];
      mpce_pkg::CFG_IMAGE_COLS: image_cols_r = data[mpce_pkg::IMG_REG_W-1:0];
      default: ;
    endcase
  endfunction

  // one accepted sample: update running max, queue a result when a window closes
  function automatic void predict_pool(pixel_t s);
    int unsigned pr, pc, ir, ic;
    bit lwc, lwr, lc, lr;
    pixel_t cur;
    pooled_t res;
    pr  = dim_used(pool_rows_r, mpce_pkg::POOL_MAX);
    pc  = dim_used(pool_cols_r, mpce_pkg::POOL_MAX);
    ir  = dim_used(image_rows_r, mpce_pkg::MAX_IMAGE_ROWS_DEF);
    ic  = dim_used(image_cols_r, mpce_pkg::MAX_IMAGE_COLS_DEF);
    lwc = col_in_win + 1 >= pc;
    lwr = row_in_win + 1 >= pr;
    lc  = col_pos + 1 >= ic;
    lr  = row_pos + 1 >= ir;
    cur = (row_in_win == 0 && col_in_win == 0) ? FLOOR : col_max[win_col];
    if (s > cur) cur = s;
    col_max[win_col] = cur;
    if ((lwc || lc) && (lwr || lr)) begin
      res.value = cur;
      res.eoi   = lc && lr;
      pending_pools.push_back(res);
    end
    if (lc) begin
      col_pos    = 0;
      col_in_win = 0;
      win_col    = 0;
      if (lr) begin
        row_pos    = 0;
        row_in_win = 0;
      end else begin
        row_pos++;
        row_in_win = lwr ? 0 : row_in_win + 1;
      end
    end else begin
      col_pos++;
      if (lwc) begin
        col_in_win = 0;
        win_col++;
      end else begin
        col_in_win++;
      end
    end
  endfunction

  function automatic pixel_t pick_sample();
    pixel_t corner [5];
    corner = '{PIX_MIN, FLOOR, PIX_MAX, pixel_t'(0), pixel_t'(-1)};
    if ($urandom_range(7) == 0) return corner[$urandom_range(4)];
    return pixel_t'($urandom);
  endfunction

  function automatic cfg_word_t pick_pool();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return cfg_word_t'($urandom_range(1, 4));
    if (r < 90) return cfg_word_t'($urandom_range(5, 16));
    return cfg_word_t'($urandom_range(0, 511));
  endfunction

  function automatic cfg_word_t pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return cfg_word_t'($urandom_range(1, 10));
    if (r < 90) return cfg_word_t'($urandom_range(11, 40));
    return cfg_word_t'($urandom_range(0, 511));
  endfunction

  task automatic pick_layout(input bit compact, output cfg_word_t pr, pc, ir, ic);
    pr = pick_pool();
    pc = pick_pool();
    if (compact) begin
      ir = cfg_word_t'($urandom_range(0, 8));
      ic = cfg_word_t'($urandom_range(0, 8));
    end else begin
      ir = pick_dim();
      ic = pick_dim();
      // keep big images to a strip
      if (dim_used(ir, mpce_pkg::MAX_IMAGE_ROWS_DEF) *
          dim_used(ic, mpce_pkg::MAX_IMAGE_COLS_DEF) > 512)
        ir = cfg_word_t'($urandom_range(0, 2));
    end
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 68; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 68; end
      default:       begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pools.size() != 0) @(posedge clk);
    // samples that close no window may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(pixel_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do begin
      @(posedge clk);
      if (!in_ready) stall_cycles++;
    end while (!in_ready);
    predict_pool(s);
    samples_sent++;
  endtask

  task automatic send_samples(int unsigned n);
    repeat (n) send_sample(pick_sample());
  endtask

  task automatic finish_image();
    do send_sample(pick_sample()); while (!at_image_start());
  endtask

  task automatic configure(cfg_word_t pr, pc, ir, ic);
    cfg_idx_t order [4];
    cfg_word_t vals [4];
    order = '{mpce_pkg::CFG_POOL_ROWS, mpce_pkg::CFG_POOL_COLS,
              mpce_pkg::CFG_IMAGE_ROWS, mpce_pkg::CFG_IMAGE_COLS};
    vals  = '{pr, pc, ir, ic};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(order[i], vals[i]);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    pooled_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (pending_pools.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %0d eoi %0b",
                                out_pooled_value, out_end_of_image));
      end else begin
        want = pending_pools.pop_front();
        if (out_pooled_value !== want.value)
          flag_mismatch($sformatf("pooled_value %0d, predicted %0d",
                                  out_pooled_value, want.value));
        if (out_end_of_image !== want.eoi)
          flag_mismatch($sformatf("end_of_image %0b, predicted %0b",
                                  out_end_of_image, want.eoi));
      end
    end
  end

  // 2x2 on 4x4 straight out of reset; windows of all-min, max, floor and mixed
  task automatic test_reset_defaults();
    pixel_t pix [16];
    pix = '{PIX_MIN, PIX_MIN, PIX_MAX,       pixel_t'(0),
            PIX_MIN, PIX_MIN, pixel_t'(-1),  pixel_t'(5),
            FLOOR,   PIX_MIN, pixel_t'(1),   pixel_t'(2),
            PIX_MIN, PIX_MIN, pixel_t'(-5),  pixel_t'(-3)};
    set_idling(IDLE_NONE);
    foreach (pix[i]) send_sample(pix[i]);
  endtask

  // partial windows at right and bottom, and a window larger than the image
  task automatic test_edge_windows();
    configure(cfg_word_t'(2), cfg_word_t'(3), cfg_word_t'(3), cfg_word_t'(4));
    finish_image();
    configure(cfg_word_t'(16), cfg_word_t'(16), cfg_word_t'(2), cfg_word_t'(2));
    finish_image();
  endtask

  // zero and out-of-range register values saturate; last pass fills every store entry
  task automatic test_register_extremes();
    set_idling(IDLE_BOTH);
    configure(cfg_word_t'(9'h011), cfg_word_t'(0), cfg_word_t'(9'h1FF), cfg_word_t'(0));
    finish_image();
    configure(cfg_word_t'(0), cfg_word_t'(9'h1FF), cfg_word_t'(0), cfg_word_t'(9'h101));
    finish_image();
    configure(cfg_word_t'(1), cfg_word_t'(1), cfg_word_t'(1), cfg_word_t'(256));
    finish_image();
  endtask

  task automatic test_backpressure();
    configure(cfg_word_t'(1), cfg_word_t'(1), cfg_word_t'(8), cfg_word_t'(8));
    set_idling(IDLE_NONE);
    hold_request = 1'b1;
    finish_image();
  endtask

  // counters carry over a register change inside an image
  task automatic test_reconfig_mid_image();
    cfg_word_t pr, pc, ir, ic;
    int unsigned n;
    repeat (8) begin
      set_idling(idle_mode_t'($urandom_range(3)));
      pick_layout(1'b1, pr, pc, ir, ic);
      configure(pr, pc, ir, ic);
      n = dim_used(ir, mpce_pkg::MAX_IMAGE_ROWS_DEF) *
          dim_used(ic, mpce_pkg::MAX_IMAGE_COLS_DEF);
      send_samples($urandom_range(1, (n > 1) ? n - 1 : 1));
      pick_layout(1'b1, pr, pc, ir, ic);
      configure(pr, pc, ir, ic);
      if (!at_image_start()) mid_image_writes++;
      if (!at_image_start()) finish_image();
    end
  endtask

  task automatic test_random_images();
    cfg_word_t pr, pc, ir, ic;
    int unsigned start, img;
    start = samples_sent;
    img   = 0;
    while (samples_sent - start < RANDOM_ITEMS) begin
      set_idling(idle_mode_t'(img % 4));
      pick_layout(1'b0, pr, pc, ir, ic);
      configure(pr, pc, ir, ic);
      finish_image();
      img++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_edge_windows();
    test_register_extremes();
    test_backpressure();
    test_reconfig_mid_image();
    test_random_images();
    wait_idle();
    if (pending_pools.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_pools.size()));
    $display("covered %0d samples, %0d pooled results, %0d register writes",
             samples_sent, results_checked, reg_writes);
    $display("input held off %0d cycles; %0d layout changes inside an image",
             stall_cycles, mid_image_writes);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout: %0d results still outstanding", pending_pools.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
